@@ hdl/lctt_pkg.sv @@
// ----------------------------------------------------------------------------
// lctt_pkg
// Types, constants and the control store of the color transition timer.
// ----------------------------------------------------------------------------
package lctt_pkg;

	localparam int unsigned DUR_W  = 32;
	localparam int unsigned PER_W  = 16;
	localparam int unsigned COL_W  = 24;
	localparam int unsigned NOW_W  = 32;
	localparam int unsigned DSR_W  = 32;
	localparam int unsigned PROD_W = 40;
	localparam int unsigned QT_W   = 10;
	localparam int unsigned QS_W   = 18;
	localparam int unsigned ADDR_W = 3;
	localparam int unsigned CFG_W  = 32;
	localparam int unsigned STEP_W = 5;

	localparam logic [PER_W-1:0] DEFAULT_PERIOD = 16'd50;
	localparam logic [QT_W-1:0]  QT_CLAMP       = 10'd512;

	localparam logic [ADDR_W-1:0] REG_DURATION = 3'd0;
	localparam logic [ADDR_W-1:0] REG_PERIOD   = 3'd1;
	localparam logic [ADDR_W-1:0] REG_START    = 3'd2;
	localparam logic [ADDR_W-1:0] REG_TARGET   = 3'd3;
	localparam logic [ADDR_W-1:0] REG_ONE_SHOT = 3'd4;

	localparam logic [1:0] KIND_START = 2'd0;
	localparam logic [1:0] KIND_TICK  = 2'd1;
	localparam logic [1:0] KIND_END   = 2'd2;

	localparam logic [1:0] DISP_NONE    = 2'd0;
	localparam logic [1:0] DISP_ADVANCE = 2'd1;
	localparam logic [1:0] DISP_REMOVE  = 2'd2;

	localparam logic [1:0] CH_RED   = 2'd0;
	localparam logic [1:0] CH_GREEN = 2'd1;
	localparam logic [1:0] CH_BLUE  = 2'd2;

	typedef logic [STEP_W-1:0] step_t;

	localparam step_t S_IDLE     = 5'd0;
	localparam step_t S_DISPATCH = 5'd1;
	localparam step_t S_ARMCHK   = 5'd2;
	localparam step_t S_ARM      = 5'd3;
	localparam step_t S_TCHK     = 5'd4;
	localparam step_t S_TSETUP   = 5'd5;
	localparam step_t S_TGET     = 5'd6;
	localparam step_t S_IDIV     = 5'd7;
	localparam step_t S_IGET     = 5'd8;
	localparam step_t S_QDIV     = 5'd9;
	localparam step_t S_QGET     = 5'd10;
	localparam step_t S_CHAN     = 5'd11;
	localparam step_t S_CDIV     = 5'd12;
	localparam step_t S_CFIN     = 5'd13;
	localparam step_t S_ECHK     = 5'd14;
	localparam step_t S_EMIT     = 5'd15;
	localparam step_t S_ENDJ     = 5'd16;
	localparam step_t S_EEND     = 5'd17;
	localparam step_t S_RESTART  = 5'd18;

	typedef enum logic [3:0] {
		ACT_NONE,
		ACT_ARM,
		ACT_TICK_SETUP,
		ACT_GET_TICKS,
		ACT_DIV_ITERS,
		ACT_GET_ITERS,
		ACT_DIV_QT,
		ACT_GET_QT,
		ACT_CH_PREP,
		ACT_DIV_CH,
		ACT_CH_FIN,
		ACT_END_EVAL,
		ACT_EMIT_RES,
		ACT_EMIT_END,
		ACT_DISARM
	} act_t;

	typedef enum logic [3:0] {
		C_NEVER,
		C_ALWAYS,
		C_NO_INPUT,
		C_RESTART,
		C_ARMED,
		C_NOT_DUE,
		C_CH_MORE,
		C_NO_RES,
		C_NO_END
	} cond_t;

	typedef struct packed {
		act_t  act;
		cond_t cond;
		step_t target;
	} uword_t;

	function automatic uword_t ucode_rom(input step_t s);
		uword_t w;
		case (s)
			S_IDLE:     w = '{ACT_NONE,       C_NO_INPUT, S_IDLE};
			S_DISPATCH: w = '{ACT_NONE,       C_RESTART,  S_RESTART};
			S_ARMCHK:   w = '{ACT_NONE,       C_ARMED,    S_TCHK};
			S_ARM:      w = '{ACT_ARM,        C_ALWAYS,   S_ECHK};
			S_TCHK:     w = '{ACT_NONE,       C_NOT_DUE,  S_ECHK};
			S_TSETUP:   w = '{ACT_TICK_SETUP, C_NEVER,    S_IDLE};
			S_TGET:     w = '{ACT_GET_TICKS,  C_NEVER,    S_IDLE};
			S_IDIV:     w = '{ACT_DIV_ITERS,  C_NEVER,    S_IDLE};
			S_IGET:     w = '{ACT_GET_ITERS,  C_NEVER,    S_IDLE};
			S_QDIV:     w = '{ACT_DIV_QT,     C_NEVER,    S_IDLE};
			S_QGET:     w = '{ACT_GET_QT,     C_NEVER,    S_IDLE};
			S_CHAN:     w = '{ACT_CH_PREP,    C_NEVER,    S_IDLE};
			S_CDIV:     w = '{ACT_DIV_CH,     C_NEVER,    S_IDLE};
			S_CFIN:     w = '{ACT_CH_FIN,     C_CH_MORE,  S_CHAN};
			S_ECHK:     w = '{ACT_END_EVAL,   C_NO_RES,   S_ENDJ};
			S_EMIT:     w = '{ACT_EMIT_RES,   C_NEVER,    S_IDLE};
			S_ENDJ:     w = '{ACT_NONE,       C_NO_END,   S_IDLE};
			S_EEND:     w = '{ACT_EMIT_END,   C_ALWAYS,   S_IDLE};
			S_RESTART:  w = '{ACT_DISARM,     C_ALWAYS,   S_IDLE};
			default:    w = '{ACT_NONE,       C_ALWAYS,   S_IDLE};
		endcase
		return w;
	endfunction

endpackage

@@ hdl/lctt_div.sv @@
// ----------------------------------------------------------------------------
// lctt_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module lctt_div import lctt_pkg::*; #(
	parameter int unsigned DW = 40
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [DW-1:0]    dividend,
	input  logic [DSR_W-1:0] divisor,
	output logic             busy,
	output logic [DW-1:0]    quo,
	output logic [DSR_W-1:0] rem
);

	localparam int unsigned CNT_W = $clog2(DW + 1);

	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic [DW-1:0]    quo_q;
	logic [DSR_W-1:0] rem_q;
	logic [DSR_W-1:0] dsr_q;
	logic [DSR_W:0]   trial;
	logic [DSR_W:0]   diff;
	logic             fits;

	assign trial = {rem_q, quo_q[DW-1]};
	assign diff  = trial - {1'b0, dsr_q};
	assign fits  = trial >= {1'b0, dsr_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= CNT_W'(DW);
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == CNT_W'(1))
				busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dsr_q <= divisor;
		end else if (busy_q) begin
			rem_q <= fits ? diff[DSR_W-1:0] : trial[DSR_W-1:0];
			quo_q <= {quo_q[DW-2:0], fits};
		end
	end

	assign busy = busy_q;
	assign quo  = quo_q;
	assign rem  = rem_q;

endmodule

@@ hdl/led_color_transition_timer.sv @@
// ----------------------------------------------------------------------------
// led_color_transition_timer
// Timed color transition emitting start, tick and end events.
// ----------------------------------------------------------------------------
// One item in flight; the next transfer is taken once the sequencer is idle.
// Restart: disarm. Start: arm and emit, End if due. Emits wait while output stalls.
// Tick: divides on the shared one-bit-per-cycle divider, DW = max(TIME_BITS, 40)
// (elapsed/period, duration/period, three channel divides, ticks/iterations),
// then emit, End if due. Results leave through one output register.
// Reset: config to defaults (period 50), timer disarmed; no clearing pass.
module led_color_transition_timer import lctt_pkg::*; #(
	parameter int unsigned TIME_BITS = 32
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_axis_tvalid,
	output logic              s_axis_tready,
	input  logic [NOW_W-1:0]  s_axis_tdata,   // now_ms
	input  logic              s_axis_tuser,   // op
	output logic              m_axis_tvalid,
	input  logic              m_axis_tready,
	output logic [31:0]       m_axis_tdata,   // red, green, blue, disposition, pad
	output logic [1:0]        m_axis_tuser,   // event_kind
	output logic              m_axis_tlast,   // last_of_run
	input  logic              cfg_we,
	input  logic [ADDR_W-1:0] cfg_addr,
	input  logic [CFG_W-1:0]  cfg_data
);

	localparam int unsigned DW = (TIME_BITS > 40) ? TIME_BITS : 40;

	// configuration
	logic [DUR_W-1:0] dur_q;
	logic [PER_W-1:0] period_q;
	logic [COL_W-1:0] start_col_q;
	logic [COL_W-1:0] target_col_q;
	logic             one_shot_q;

	// timer state
	logic                 armed_q;
	logic [TIME_BITS-1:0] fin_q;
	logic [TIME_BITS-1:0] tick_q;

	// sequencer
	step_t  step_q;
	step_t  step_nxt;
	uword_t uw;
	logic   stall;
	logic   jump;
	logic   s_fire;
	logic   out_busy;
	logic   res_q;
	logic   end_q;
	logic [1:0] ch_q;

	// datapath
	logic [TIME_BITS-1:0] now_q;
	logic                 op_q;
	logic [TIME_BITS-1:0] now_t;
	logic [TIME_BITS-1:0] dur_t;
	logic [PER_W-1:0]     per_eff;
	logic [TIME_BITS-1:0] per_t;
	logic [TIME_BITS-1:0] elapsed;
	logic [TIME_BITS-1:0] ticks_q;
	logic [DSR_W-1:0]     iters_q;
	logic [QT_W-1:0]      qt_q;
	logic [DSR_W-1:0]     rt_q;
	logic [7:0]           from_c;
	logic [7:0]           to_c;
	logic [7:0]           mag_c;
	logic [7:0]           from_q;
	logic [7:0]           mag_q;
	logic                 down_q;
	logic [PROD_W-1:0]    prod_q;
	logic [QS_W-1:0]      qsum;
	logic [QS_W-1:0]      upsum;
	logic [7:0]           value_c;
	logic [1:0]           res_kind_q;
	logic [COL_W-1:0]     res_col_q;

	// divider
	logic             div_start;
	logic [DW-1:0]    div_dvd;
	logic [DSR_W-1:0] div_dsr;
	logic             div_busy;
	logic [DW-1:0]    div_quo;
	logic [DSR_W-1:0] div_rem;

	// output register
	logic             m_valid_q;
	logic [1:0]       m_kind_q;
	logic [COL_W-1:0] m_col_q;
	logic [1:0]       m_disp_q;
	logic             m_last_q;

	function automatic logic [7:0] chan_byte(input logic [COL_W-1:0] col,
		input logic [1:0] ch);
		logic [7:0] b;
		case (ch)
			CH_RED:   b = col[23:16];
			CH_GREEN: b = col[15:8];
			CH_BLUE:  b = col[7:0];
			default:  b = col[7:0];
		endcase
		return b;
	endfunction

	assign now_t   = TIME_BITS'(s_axis_tdata);
	assign dur_t   = TIME_BITS'(dur_q);
	assign per_eff = (period_q == '0) ? PER_W'(1) : period_q;
	assign per_t   = TIME_BITS'(per_eff);
	assign elapsed = now_q - (fin_q - dur_t);

	assign uw            = ucode_rom(step_q);
	assign s_axis_tready = (step_q == S_IDLE);
	assign s_fire        = s_axis_tvalid && s_axis_tready;
	assign out_busy      = m_valid_q && !m_axis_tready;

	always_comb begin
		case (uw.act)
			ACT_GET_TICKS, ACT_GET_ITERS, ACT_GET_QT, ACT_CH_FIN: stall = div_busy;
			ACT_EMIT_RES, ACT_EMIT_END:                           stall = out_busy;
			default:                                              stall = 1'b0;
		endcase
	end

	always_comb begin
		case (uw.cond)
			C_NEVER:    jump = 1'b0;
			C_ALWAYS:   jump = 1'b1;
			C_NO_INPUT: jump = !s_fire;
			C_RESTART:  jump = op_q;
			C_ARMED:    jump = armed_q;
			C_NOT_DUE:  jump = tick_q > now_q;
			C_CH_MORE:  jump = ch_q != CH_BLUE;
			C_NO_RES:   jump = !res_q;
			C_NO_END:   jump = !end_q;
			default:    jump = 1'b0;
		endcase
	end

	always_comb begin
		if (stall)
			step_nxt = step_q;
		else if (jump)
			step_nxt = uw.target;
		else
			step_nxt = step_q + 1'b1;
	end

	// divider operand select
	always_comb begin
		div_start = 1'b0;
		div_dvd   = '0;
		div_dsr   = iters_q;
		case (uw.act)
			ACT_TICK_SETUP: begin
				div_start = 1'b1;
				div_dvd   = DW'(elapsed);
				div_dsr   = DSR_W'(per_eff);
			end
			ACT_DIV_ITERS: begin
				div_start = 1'b1;
				div_dvd   = DW'(dur_q);
				div_dsr   = DSR_W'(per_eff);
			end
			ACT_DIV_QT: begin
				div_start = 1'b1;
				div_dvd   = DW'(ticks_q);
			end
			ACT_DIV_CH: begin
				div_start = 1'b1;
				div_dvd   = DW'(prod_q);
			end
			default: ;
		endcase
	end

	lctt_div #(
		.DW(DW)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dvd),
		.divisor  (div_dsr),
		.busy     (div_busy),
		.quo      (div_quo),
		.rem      (div_rem)
	);

	// per-channel interpolation
	assign from_c  = chan_byte(start_col_q, ch_q);
	assign to_c    = chan_byte(target_col_q, ch_q);
	assign mag_c   = (from_c >= to_c) ? from_c - to_c : to_c - from_c;
	assign qsum    = QS_W'(mag_q) * QS_W'(qt_q) + QS_W'(div_quo[7:0]);
	assign upsum   = QS_W'(from_q) + qsum;

	always_comb begin
		if (down_q)
			value_c = (qsum > QS_W'(from_q)) ? 8'h00 : from_q - qsum[7:0];
		else
			value_c = (upsum > QS_W'(8'hFF)) ? 8'hFF : upsum[7:0];
	end

	// control and architectural state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dur_q        <= '0;
			period_q     <= DEFAULT_PERIOD;
			start_col_q  <= '0;
			target_col_q <= '0;
			one_shot_q   <= 1'b0;
			armed_q      <= 1'b0;
			fin_q        <= '0;
			tick_q       <= '0;
			step_q       <= S_IDLE;
			res_q        <= 1'b0;
			end_q        <= 1'b0;
			ch_q         <= CH_RED;
			m_valid_q    <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_addr)
					REG_DURATION: dur_q        <= cfg_data[DUR_W-1:0];
					REG_PERIOD:   period_q     <= cfg_data[PER_W-1:0];
					REG_START:    start_col_q  <= cfg_data[COL_W-1:0];
					REG_TARGET:   target_col_q <= cfg_data[COL_W-1:0];
					REG_ONE_SHOT: one_shot_q   <= cfg_data[0];
					default: ;
				endcase
			end

			step_q <= step_nxt;
			if (s_fire)
				res_q <= 1'b0;

			if (!stall && (uw.act == ACT_EMIT_RES || uw.act == ACT_EMIT_END))
				m_valid_q <= 1'b1;
			else if (m_axis_tready)
				m_valid_q <= 1'b0;

			if (!stall) begin
				case (uw.act)
					ACT_ARM: begin
						armed_q <= 1'b1;
						fin_q   <= now_q + dur_t;
						tick_q  <= now_q + per_t;
						res_q   <= 1'b1;
					end
					ACT_TICK_SETUP: begin
						tick_q <= now_q + per_t;
						res_q  <= 1'b1;
					end
					ACT_GET_QT:   ch_q  <= CH_RED;
					ACT_CH_FIN:   ch_q  <= ch_q + 1'b1;
					ACT_END_EVAL: end_q <= (dur_q != '0) && (fin_q <= now_q);
					ACT_EMIT_END: begin
						armed_q   <= 1'b0;
						fin_q     <= '0;
						tick_q    <= '0;
					end
					ACT_DISARM: begin
						armed_q <= 1'b0;
						fin_q   <= '0;
						tick_q  <= '0;
					end
					default: ;
				endcase
			end
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (s_fire) begin
			now_q <= now_t;
			op_q  <= s_axis_tuser;
		end
		if (!stall) begin
			case (uw.act)
				ACT_ARM: begin
					res_kind_q <= KIND_START;
					res_col_q  <= start_col_q;
				end
				ACT_TICK_SETUP: res_kind_q <= KIND_TICK;
				ACT_GET_TICKS:  ticks_q <= div_quo[TIME_BITS-1:0];
				ACT_GET_ITERS:  iters_q <= (div_quo[DSR_W-1:0] == '0) ?
					DSR_W'(1) : div_quo[DSR_W-1:0];
				ACT_GET_QT: begin
					qt_q <= (div_quo > DW'(QT_CLAMP)) ? QT_CLAMP : div_quo[QT_W-1:0];
					rt_q <= div_rem;
				end
				ACT_CH_PREP: begin
					from_q <= from_c;
					mag_q  <= mag_c;
					down_q <= from_c >= to_c;
					prod_q <= PROD_W'(mag_c) * PROD_W'(rt_q);
				end
				ACT_CH_FIN: begin
					case (ch_q)
						CH_RED:   res_col_q[23:16] <= value_c;
						CH_GREEN: res_col_q[15:8]  <= value_c;
						default:  res_col_q[7:0]   <= value_c;
					endcase
				end
				ACT_EMIT_RES: begin
					m_kind_q <= res_kind_q;
					m_col_q  <= res_col_q;
					m_disp_q <= DISP_NONE;
					m_last_q <= !end_q;
				end
				ACT_EMIT_END: begin
					m_kind_q <= KIND_END;
					m_col_q  <= target_col_q;
					m_disp_q <= one_shot_q ? DISP_REMOVE : DISP_ADVANCE;
					m_last_q <= 1'b1;
				end
				default: ;
			endcase
		end
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tuser  = m_kind_q;
	assign m_axis_tlast  = m_last_q;
	assign m_axis_tdata  = {6'b0, m_disp_q, m_col_q[7:0], m_col_q[15:8], m_col_q[23:16]};

endmodule

@@ dv/tb_top.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Checks the color transition timer: time samples and restarts go in as
// stream transfers, and a local timer model predicts each start, tick and end
// event. Directed runs cover defaults, one-shot and advance ends, finish time
// wrap, zero period, free running and extreme registers. Random runs follow.
// ----------------------------------------------------------------------------
module tb_top import lctt_pkg::*; ();

	localparam logic OP_SAMPLE  = 1'b0;
	localparam logic OP_RESTART = 1'b1;
	localparam int unsigned CYCLE_LIMIT  = 3000000;
	localparam int unsigned DRAIN_CYCLES = 400;

	typedef struct {
		logic [1:0] kind;
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
		logic [1:0] disp;
		logic       last;
	} timer_event_t;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              s_axis_tvalid = 1'b0;
	logic              s_axis_tready;
	logic [NOW_W-1:0]  s_axis_tdata = '0;   // now_ms
	logic              s_axis_tuser = 1'b0; // op
	logic              m_axis_tvalid;
	logic              m_axis_tready = 1'b0;
	logic [31:0]       m_axis_tdata;        // red, green, blue, disposition, pad
	logic [1:0]        m_axis_tuser;        // event_kind
	logic              m_axis_tlast;        // last_of_run
	logic              cfg_we = 1'b0;
	logic [ADDR_W-1:0] cfg_addr = '0;
	logic [CFG_W-1:0]  cfg_data = '0;

	// timer model: registers and state
	logic [31:0] duration_ms;
	logic [15:0] period_ms;
	logic [23:0] start_col;
	logic [23:0] target_col;
	logic        one_shot;
	logic        armed;
	logic [31:0] finish_at;
	logic [31:0] next_tick_at;

	timer_event_t pending_events[$];
	timer_event_t want;
	int unsigned  mismatches = 0;
	int unsigned  cycles = 0;
	bit           src_idle = 1'b1;
	bit           snk_idle = 1'b1;

	led_color_transition_timer uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.s_axis_tuser (s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.m_axis_tuser (m_axis_tuser),
		.m_axis_tlast (m_axis_tlast),
		.cfg_we       (cfg_we),
		.cfg_addr     (cfg_addr),
		.cfg_data     (cfg_data)
	);

	always #6 clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("FAIL led_color_transition_timer");
			$finish;
		end
	end

	function automatic logic [7:0] blend_channel(input logic [7:0] from, input logic [7:0] to,
			input logic [63:0] ticks, input logic [63:0] iters);
		logic [63:0] mag;
		logic [63:0] whole;
		logic [63:0] frac;
		logic [63:0] q;
		logic        down;
		down = from >= to;
		mag = down ? 64'(from) - 64'(to) : 64'(to) - 64'(from);
		if (mag == 0)
			return from;
		whole = ticks / iters;
		frac = ticks % iters;
		if (whole > 64'd512)
			whole = 64'd512;
		q = mag * whole + (mag * frac) / iters;
		if (down)
			return (q > 64'(from)) ? 8'd0 : 8'(64'(from) - q);
		return (64'(from) + q > 64'd255) ? 8'd255 : 8'(64'(from) + q);
	endfunction

	function automatic timer_event_t make_event(input logic [1:0] kind, input logic [23:0] col,
			input logic [1:0] disp);
		timer_event_t e;
		e.kind = kind;
		e.red = col[23:16];
		e.green = col[15:8];
		e.blue = col[7:0];
		e.disp = disp;
		e.last = 1'b0;
		return e;
	endfunction

	task automatic advance_timer(input logic op, input logic [31:0] t_ms);
		timer_event_t evs[2];
		int          n;
		logic [63:0] per;
		logic [31:0] origin;
		logic [63:0] ticks;
		logic [63:0] iters;
		logic [23:0] col;
		n = 0;
		per = (period_ms == 0) ? 64'd1 : 64'(period_ms);
		if (op == OP_RESTART) begin
			armed = 1'b0;
			finish_at = '0;
			next_tick_at = '0;
			return;
		end
		if (!armed) begin
			armed = 1'b1;
			finish_at = t_ms + duration_ms;
			next_tick_at = t_ms + 32'(per);
			evs[n] = make_event(KIND_START, start_col, DISP_NONE);
			n++;
		end else if (next_tick_at <= t_ms) begin
			origin = finish_at - duration_ms;
			ticks = 64'(32'(t_ms - origin)) / per;
			iters = 64'(duration_ms) / per;
			if (iters == 0)
				iters = 64'd1;
			next_tick_at = t_ms + 32'(per);
			col = {blend_channel(start_col[23:16], target_col[23:16], ticks, iters),
				blend_channel(start_col[15:8], target_col[15:8], ticks, iters),
				blend_channel(start_col[7:0], target_col[7:0], ticks, iters)};
			evs[n] = make_event(KIND_TICK, col, DISP_NONE);
			n++;
		end
		if (duration_ms != 0 && finish_at <= t_ms) begin
			evs[n] = make_event(KIND_END, target_col, one_shot ? DISP_REMOVE : DISP_ADVANCE);
			n++;
			armed = 1'b0;
			finish_at = '0;
			next_tick_at = '0;
		end
		if (n > 0)
			evs[n-1].last = 1'b1;
		for (int i = 0; i < n; i++)
			pending_events.push_back(evs[i]);
	endtask

	task automatic send_item(input logic op, input logic [31:0] t_ms);
		int unsigned gap;
		gap = src_idle ? $urandom_range(0, 7) : 0;
		@(negedge clk);
		if (gap != 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= t_ms;
		s_axis_tuser <= op;
		do @(posedge clk); while (!s_axis_tready);
		advance_timer(op, t_ms);
	endtask

	task automatic wait_idle();
		@(negedge clk);
		s_axis_tvalid <= 1'b0;
		while (pending_events.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [ADDR_W-1:0] idx, input logic [CFG_W-1:0] value);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_addr <= idx;
		cfg_data <= value;
		@(negedge clk);
		cfg_we <= 1'b0;
		case (idx)
			REG_DURATION: duration_ms = value;
			REG_PERIOD:   period_ms = value[15:0];
			REG_START:    start_col = value[23:0];
			REG_TARGET:   target_col = value[23:0];
			REG_ONE_SHOT: one_shot = value[0];
			default: ;
		endcase
	endtask

	task automatic load_timer(input logic [31:0] dur, input logic [15:0] per,
			input logic [23:0] from, input logic [23:0] to, input logic once);
		wait_idle();
		write_reg(REG_DURATION, dur);
		write_reg(REG_PERIOD, CFG_W'(per));
		write_reg(REG_START, CFG_W'(from));
		write_reg(REG_TARGET, CFG_W'(to));
		write_reg(REG_ONE_SHOT, CFG_W'(once));
	endtask

	// output side pacing
	always begin : sink_pacing
		int unsigned stall;
		stall = snk_idle ? $urandom_range(0, 7) : 0;
		@(negedge clk);
		if (stall != 0) begin
			m_axis_tready <= 1'b0;
			repeat (stall) @(negedge clk);
		end
		m_axis_tready <= 1'b1;
		do @(posedge clk); while (m_axis_tvalid !== 1'b1);
	end

	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (pending_events.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected event kind %0d data %h last %0b",
						m_axis_tuser, m_axis_tdata, m_axis_tlast);
			end else begin
				want = pending_events.pop_front();
				if (m_axis_tuser !== want.kind || m_axis_tdata[7:0] !== want.red ||
						m_axis_tdata[15:8] !== want.green || m_axis_tdata[23:16] !== want.blue ||
						m_axis_tdata[25:24] !== want.disp || m_axis_tlast !== want.last) begin
					mismatches++;
					if (mismatches <= 10) begin
						$display("mismatch: exp kind %0d rgb %h %h %h disp %0d last %0b",
							want.kind, want.red, want.green, want.blue, want.disp, want.last);
						$display("          got kind %0d rgb %h %h %h disp %0d last %0b",
							m_axis_tuser, m_axis_tdata[7:0], m_axis_tdata[15:8],
							m_axis_tdata[23:16], m_axis_tdata[25:24], m_axis_tlast);
					end
				end
			end
		end
	end

	task automatic test_default_config();
		send_item(OP_SAMPLE, 32'd0);
		send_item(OP_SAMPLE, 32'd49);
		send_item(OP_SAMPLE, 32'd50);
		send_item(OP_RESTART, 32'hFFFF_FFFF);
	endtask

	task automatic test_transition_run();
		load_timer(32'd200, 16'd20, 24'hFF0080, 24'h00FF80, 1'b0);
		send_item(OP_SAMPLE, 32'd1000);
		send_item(OP_SAMPLE, 32'd1020);
		send_item(OP_SAMPLE, 32'd1105);
		send_item(OP_SAMPLE, 32'd1200);
	endtask

	task automatic test_one_shot_end();
		load_timer(32'd200, 16'd20, 24'h000000, 24'hFFFFFF, 1'b1);
		send_item(OP_SAMPLE, 32'd5000);
		send_item(OP_SAMPLE, 32'd5300);
		send_item(OP_SAMPLE, 32'd6000);
		send_item(OP_RESTART, 32'd0);
		send_item(OP_SAMPLE, 32'd6001);
	endtask

	task automatic test_finish_wrap();
		load_timer(32'd100, 16'd50, 24'h123456, 24'hABCDEF, 1'b0);
		send_item(OP_SAMPLE, 32'hFFFF_FFC0);
		send_item(OP_SAMPLE, 32'd0);
		send_item(OP_RESTART, 32'd0);
	endtask

	task automatic test_period_zero();
		load_timer(32'd5, 16'd0, 24'h80FF00, 24'h0000FF, 1'b0);
		send_item(OP_SAMPLE, 32'd10);
		send_item(OP_SAMPLE, 32'd11);
		send_item(OP_SAMPLE, 32'd15);
	endtask

	task automatic test_free_running();
		load_timer(32'd0, 16'd1, 24'h10F080, 24'hF01080, 1'b0);
		send_item(OP_SAMPLE, 32'd7);
		send_item(OP_SAMPLE, 32'd10);
		send_item(OP_SAMPLE, 32'd100007);
	endtask

	task automatic test_extreme_registers();
		load_timer(32'hFFFF_FFFF, 16'hFFFF, 24'hFFFFFF, 24'h000000, 1'b1);
		send_item(OP_RESTART, 32'd0);
		send_item(OP_SAMPLE, 32'd0);
		send_item(OP_SAMPLE, 32'h0000_FFFF);
		send_item(OP_SAMPLE, 32'hFFFF_FFFF);
	endtask

	task automatic test_random_runs();
		logic [31:0] dur;
		logic [15:0] per;
		logic [23:0] from;
		logic [23:0] to;
		logic [31:0] t_ms;
		int unsigned eff;
		int unsigned pick;
		for (int phase = 0; phase < 8; phase++) begin
			case ($urandom_range(0, 9))
				0:       dur = 32'd0;
				1:       dur = 32'hFFFF_FFFF;
				2:       dur = $urandom;
				default: dur = $urandom_range(1, 3000);
			endcase
			case ($urandom_range(0, 9))
				0:       per = 16'd1;
				1:       per = 16'hFFFF;
				2:       per = 16'($urandom_range(1, 65535));
				default: per = 16'($urandom_range(1, 200));
			endcase
			from = ($urandom_range(0, 7) == 0) ? 24'hFFFFFF : 24'($urandom);
			to = ($urandom_range(0, 7) == 0) ? 24'h000000 : 24'($urandom);
			load_timer(dur, per, from, to, 1'($urandom));
			send_item(OP_RESTART, $urandom);
			eff = (per == 16'd0) ? 1 : 32'(per);
			t_ms = ($urandom_range(0, 3) == 0) ? 32'hFFFF_FFFF - $urandom_range(0, 5000) : $urandom;
			for (int i = 0; i < 250; i++) begin
				if (i % 50 == 0) begin
					src_idle = $urandom_range(0, 3) != 0;
					snk_idle = $urandom_range(0, 3) != 0;
				end
				pick = $urandom_range(0, 99);
				if (pick < 4) begin
					send_item(OP_RESTART, $urandom);
				end else if (pick < 8) begin
					t_ms = $urandom;
					send_item(OP_SAMPLE, t_ms);
				end else begin
					t_ms = t_ms + $urandom_range(0, 2 * eff);
					send_item(OP_SAMPLE, t_ms);
				end
			end
		end
		src_idle = 1'b1;
		snk_idle = 1'b1;
	endtask

	initial begin
		duration_ms = '0;
		period_ms = DEFAULT_PERIOD;
		start_col = '0;
		target_col = '0;
		one_shot = 1'b0;
		armed = 1'b0;
		finish_at = '0;
		next_tick_at = '0;
		repeat (11) @(negedge clk);
		arst_n = 1'b1;
		test_default_config();
		test_transition_run();
		test_one_shot_end();
		test_finish_wrap();
		test_period_zero();
		test_free_running();
		test_extreme_registers();
		test_random_runs();
		wait_idle();
		if (mismatches == 0 && pending_events.size() == 0) begin
			$display("PASS led_color_transition_timer");
		end else begin
			$display("FAIL led_color_transition_timer");
		end
		$finish;
	end

endmodule

@@ filelist.f @@
hdl/lctt_pkg.sv
hdl/lctt_div.sv
hdl/led_color_transition_timer.sv
dv/tb_top.sv
